// ----- rtl/msp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants of the motor speed PI controller
// Register indexes, control state, the config bundle and sequencer controls.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd7;

  // Reset values
  localparam logic [30:0] TIME_STEP_RST  = 31'd66;
  localparam logic [15:0] PWM_PERIOD_RST = 16'd1000;

  // Drive limit, +/- 1.0 in Q16.16
  localparam logic signed [47:0] DRIVE_MAX = 48'sd65536;
  localparam logic signed [47:0] DRIVE_MIN = -48'sd65536;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic [30:0]        prop_gain;
    logic [30:0]        integ_gain;
    logic [30:0]        integral_limit;
    logic signed [31:0] speed_scale;
    logic [30:0]        time_step;
    logic [15:0]        pwm_period;
    logic [15:0]        deadband;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SPEED,
    ST_ERROR,
    ST_MUL_STEP,
    ST_INTEG,
    ST_MUL_PROP,
    ST_MUL_IGAIN,
    ST_DRIVE,
    ST_MUL_PWM,
    ST_OUTPUT
  } state_t;

  // Operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    OP_SPEED,
    OP_STEP,
    OP_PROP,
    OP_IGAIN,
    OP_PWM
  } mul_sel_t;

  typedef struct packed {
    logic     take_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     ld_error;
    logic     ld_integ;
    logic     ld_acc;
    logic     ld_drive;
    logic     ld_out;
  } ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/motor_speed_pi_controller_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// motor_speed_pi_controller_core: PI speed loop with anti-windup clamp
// Encoder count in, speed, drive level, PWM compare and direction out.
// ----------------------------------------------------------------------------
//  channel   | dir | width | beat contents
//  s_axis    | in  | 16    | encoder_count
//  m_axis    | out | 72    | measured_speed, drive_level, duty_compare, direction
//  cfg       | in  | 3+32  | register index, write data
//
//  A tick runs from the input beat through the sequencer steps to the result
//  register, and the next input beat is taken only back in idle: five
//  products share one registered 32x32 multiplier, each one used by the step
//  after it. The input side is ready only while the sequencer is idle.
//  The result register frees the input side while a result waits; a stalled
//  output holds the sequencer in its last step. Reset is synchronous, no
//  clearing pass.
// ----------------------------------------------------------------------------
module motor_speed_pi_controller_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [15:0]                    s_tdata,  // [15:0] encoder_count
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [31:0] measured_speed, [49:32] drive_level, [65:50] duty_compare,
  // [66] direction, [71:67] zero
  output logic [71:0]                         m_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [msp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [msp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import msp_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;
  logic  out_busy;

  logic signed [15:0] count;
  logic signed [31:0] speed;
  logic signed [31:0] error;
  logic signed [31:0] integral_sum;
  logic signed [47:0] acc;
  logic signed [17:0] drive;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;

  logic signed [39:0] speed_sh;
  logic signed [31:0] speed_sat;
  logic signed [32:0] err_diff;
  logic signed [31:0] err_sat;
  logic signed [47:0] integ_sum;
  logic signed [47:0] lim_pos;
  logic signed [47:0] lim_neg;
  logic signed [31:0] integ_clamp;
  logic signed [47:0] drive_sum;
  logic signed [17:0] drive_clamp;
  logic [16:0]        mag;
  logic [15:0]        pulse;
  logic [15:0]        duty;

  msp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_busy = m_tvalid && !m_tready;

  msp_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_busy (out_busy),
    .ctrl     (ctrl)
  );

  assign s_tready = ctrl.take_in;

  // Operand select for the shared multiplier
  assign mag = drive[17] ? 17'(-drive) : drive[16:0];

  always_comb begin
    case (ctrl.mul_sel)
      OP_SPEED: begin
        mul_a = 32'(count);
        mul_b = cfg.speed_scale;
      end
      OP_STEP: begin
        mul_a = error;
        mul_b = {1'b0, cfg.time_step};
      end
      OP_PROP: begin
        mul_a = error;
        mul_b = {1'b0, cfg.prop_gain};
      end
      OP_IGAIN: begin
        mul_a = integral_sum;
        mul_b = {1'b0, cfg.integ_gain};
      end
      OP_PWM: begin
        mul_a = {15'd0, mag};
        mul_b = {16'd0, cfg.pwm_period};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  msp_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Speed: floor(count * scale / 2^8), saturated; error against setpoint
  assign speed_sh = prod[47:8];
  always_comb begin
    if (speed_sh > 40'sh007FFFFFFF) begin
      speed_sat = 32'sh7FFFFFFF;
    end else if (speed_sh < -40'sh0080000000) begin
      speed_sat = 32'sh80000000;
    end else begin
      speed_sat = speed_sh[31:0];
    end
  end

  assign err_diff = 33'(cfg.setpoint) - 33'(speed_sat);
  always_comb begin
    if (err_diff > 33'sh07FFFFFFF) begin
      err_sat = 32'sh7FFFFFFF;
    end else if (err_diff < -33'sh080000000) begin
      err_sat = 32'sh80000000;
    end else begin
      err_sat = err_diff[31:0];
    end
  end

  // Integral: add floor(error * step / 2^16), clamp to +/- limit
  assign integ_sum = 48'(integral_sum) + $signed(prod[63:16]);
  assign lim_pos   = {17'd0, cfg.integral_limit};
  assign lim_neg   = -lim_pos;
  always_comb begin
    if (integ_sum > lim_pos) begin
      integ_clamp = 32'(lim_pos);
    end else if (integ_sum < lim_neg) begin
      integ_clamp = 32'(lim_neg);
    end else begin
      integ_clamp = integ_sum[31:0];
    end
  end

  // Drive: proportional term plus integral term, clamped to +/- 1.0
  assign drive_sum = acc + $signed(prod[63:16]);
  always_comb begin
    if (drive_sum > DRIVE_MAX) begin
      drive_clamp = 18'(DRIVE_MAX);
    end else if (drive_sum < DRIVE_MIN) begin
      drive_clamp = 18'(DRIVE_MIN);
    end else begin
      drive_clamp = drive_sum[17:0];
    end
  end

  // PWM compare with deadband
  assign pulse = prod[31:16];
  assign duty  = (pulse <= cfg.deadband) ? 16'd0 : pulse;

  // Datapath registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      count <= s_tdata;
    end
    if (ctrl.ld_error) begin
      speed <= speed_sat;
      error <= err_sat;
    end
    if (ctrl.ld_acc) begin
      acc <= $signed(prod[63:16]);
    end
    if (ctrl.ld_drive) begin
      drive <= drive_clamp;
    end
  end

  // Integral state
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
    end else if (ctrl.ld_integ) begin
      integral_sum <= integ_clamp;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.ld_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      m_tdata <= {5'd0, (drive > 18'sd0), duty, drive, speed};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/msp_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msp_cfg: configuration register file
// Eight write-only registers, loaded from the plain write port.
// ----------------------------------------------------------------------------
module msp_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [msp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [msp_pkg::CFG_DATA_W-1:0] cfg_data,
  output msp_pkg::cfg_t                       cfg
);
  import msp_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.setpoint       <= '0;
      regs.prop_gain      <= '0;
      regs.integ_gain     <= '0;
      regs.integral_limit <= '0;
      regs.speed_scale    <= '0;
      regs.time_step      <= TIME_STEP_RST;
      regs.pwm_period     <= PWM_PERIOD_RST;
      regs.deadband       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETPOINT:   regs.setpoint       <= cfg_data;
        REG_PROP_GAIN:  regs.prop_gain      <= cfg_data[30:0];
        REG_INTEG_GAIN: regs.integ_gain     <= cfg_data[30:0];
        REG_INTEG_LIM:  regs.integral_limit <= cfg_data[30:0];
        REG_SPEED_SCL:  regs.speed_scale    <= cfg_data;
        REG_TIME_STEP:  regs.time_step      <= cfg_data[30:0];
        REG_PWM_PERIOD: regs.pwm_period     <= cfg_data[15:0];
        REG_DEADBAND:   regs.deadband       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule
`default_nettype wire

// ----- rtl/msp_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msp_mul: shared signed multiplier
// One 32x32 signed multiply per enabled cycle, product registered.
// ----------------------------------------------------------------------------
module msp_mul (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [63:0]      prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/msp_fsm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msp_fsm: control tick sequencer
// Steps one tick through the shared multiplier and the datapath loads.
// ----------------------------------------------------------------------------
module msp_fsm (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     out_busy,
  output msp_pkg::ctrl_t ctrl
);
  import msp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_MUL_SPEED;
      ST_MUL_SPEED: state_next = ST_ERROR;
      ST_ERROR:     state_next = ST_MUL_STEP;
      ST_MUL_STEP:  state_next = ST_INTEG;
      ST_INTEG:     state_next = ST_MUL_PROP;
      ST_MUL_PROP:  state_next = ST_MUL_IGAIN;
      ST_MUL_IGAIN: state_next = ST_DRIVE;
      ST_DRIVE:     state_next = ST_MUL_PWM;
      ST_MUL_PWM:   state_next = ST_OUTPUT;
      ST_OUTPUT:    if (!out_busy) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl = '0;
    ctrl.mul_sel = OP_SPEED;
    unique case (state)
      ST_IDLE:      ctrl.take_in = 1'b1;
      ST_MUL_SPEED: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = OP_SPEED;
      end
      ST_ERROR:     ctrl.ld_error = 1'b1;
      ST_MUL_STEP:  begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = OP_STEP;
      end
      ST_INTEG:     ctrl.ld_integ = 1'b1;
      ST_MUL_PROP:  begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = OP_PROP;
      end
      ST_MUL_IGAIN: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = OP_IGAIN;
        ctrl.ld_acc  = 1'b1;
      end
      ST_DRIVE:     ctrl.ld_drive = 1'b1;
      ST_MUL_PWM:   begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = OP_PWM;
      end
      ST_OUTPUT:    ctrl.ld_out = !out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for motor_speed_pi_controller_core
// Drives encoder-count beats and register writes, predicts speed, drive,
// duty and direction for every tick, and compares each output beat field by
// field. A directed table comes first, then randomized register phases.
// ----------------------------------------------------------------------------
module testbench;
  import msp_pkg::*;

  localparam int     STALL_LIMIT = 5000;
  localparam int     PHASES      = 14;
  localparam int     PHASE_TICKS = 125;
  localparam longint S32_MAX     = 64'sd2147483647;
  localparam longint S32_MIN     = -S32_MAX - 1;

  // One output beat, unpacked from m_tdata
  typedef struct packed {
    logic [31:0] speed;
    logic [17:0] drive;
    logic [15:0] duty;
    logic        dir;
  } tick_result_t;

  // Directed table row: a register write or a tick, optionally with a
  // hand-written expectation
  typedef struct packed {
    bit           is_cfg;
    logic [2:0]   idx;
    logic [31:0]  data;
    logic [15:0]  cnt;
    bit           typed;
    tick_result_t want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;   // [15:0] encoder_count
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [31:0] measured_speed, [49:32] drive_level, [65:50] duty_compare,
  // [66] direction, [71:67] zero
  logic [71:0]           m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Controller settings and integrator, tracked on the bench side
  longint ctl_setpoint = 0;
  longint ctl_kp       = 0;
  longint ctl_ki       = 0;
  longint ctl_ilim     = 0;
  longint ctl_scale    = 0;
  longint ctl_dt       = longint'(TIME_STEP_RST);
  longint ctl_period   = longint'(PWM_PERIOD_RST);
  longint ctl_deadband = 0;
  longint integ_acc    = 0;

  tick_result_t pending_ticks[$];
  dir_row_t     directed_rows[$];
  int unsigned  mismatches   = 0;
  int unsigned  results_seen = 0;
  int unsigned  stall_cycles = 0;
  bit           quiet        = 1'b0;

  motor_speed_pi_controller_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint clamp_long(input longint x, input longint lo,
                                        input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // One control tick: speed, error, clamped integral, drive, duty
  function automatic tick_result_t next_tick(input logic [15:0] cnt);
    longint       spd, err, acc, drv, mag, pulse;
    tick_result_t r;
    spd = clamp_long((longint'($signed(cnt)) * ctl_scale) >>> 8, S32_MIN, S32_MAX);
    err = clamp_long(ctl_setpoint - spd, S32_MIN, S32_MAX);
    acc = clamp_long(integ_acc + ((err * ctl_dt) >>> 16), -ctl_ilim, ctl_ilim);
    integ_acc = acc;
    drv = clamp_long(((ctl_kp * err) >>> 16) + ((ctl_ki * acc) >>> 16),
                     longint'(DRIVE_MIN), longint'(DRIVE_MAX));
    mag = (drv < 0) ? -drv : drv;
    pulse = (mag * ctl_period) >>> 16;
    if (pulse <= ctl_deadband) pulse = 0;
    r.speed = spd[31:0];
    r.drive = drv[17:0];
    r.duty  = pulse[15:0];
    r.dir   = (drv > 0);
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [2:0] idx, input logic [31:0] data);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic dir_row_t tick_row(input logic [15:0] cnt);
    dir_row_t r;
    r = '0;
    r.cnt = cnt;
    return r;
  endfunction

  function automatic dir_row_t known_row(input logic [15:0] cnt, input logic [31:0] spd,
                                         input logic [17:0] drv, input logic [15:0] duty,
                                         input logic dir);
    dir_row_t r;
    r = tick_row(cnt);
    r.typed = 1'b1;
    r.want  = '{speed: spd, drive: drv, duty: duty, dir: dir};
    return r;
  endfunction

  // Log-uniform magnitude of up to bits wide
  function automatic logic [31:0] rand_mag(input int unsigned bits);
    int unsigned w;
    logic [31:0] v;
    w = $urandom_range(0, bits);
    v = $urandom;
    return (w >= 32) ? v : (v & ((32'd1 << w) - 32'd1));
  endfunction

  function automatic logic [31:0] rand_reg(input logic [2:0] idx);
    logic [31:0] v;
    bit          pick_end;
    pick_end = ($urandom_range(0, 7) == 0);
    case (idx)
      REG_SETPOINT, REG_SPEED_SCL: begin
        v = rand_mag(31);
        if ($urandom_range(0, 1)) v = -v;
        if (pick_end) begin
          case ($urandom_range(0, 2))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            default: v = '0;
          endcase
        end
      end
      REG_PWM_PERIOD, REG_DEADBAND: begin
        v = rand_mag(16);
        if (pick_end) v = $urandom_range(0, 1) ? 32'hFFFF
                          : ((idx == REG_PWM_PERIOD) ? 32'd1 : 32'd0);
      end
      default: begin
        v = rand_mag(31);
        if (pick_end) v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'd0;
      end
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_count();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0, 1: v = 16'($urandom);
      2:    v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: begin
        v = 16'(rand_mag(15));
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatches++;
  endtask

  // Register write; cfg_we is left high so back-to-back writes need no gap
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_SETPOINT:   ctl_setpoint = longint'($signed(data));
      REG_PROP_GAIN:  ctl_kp       = longint'(data[30:0]);
      REG_INTEG_GAIN: ctl_ki       = longint'(data[30:0]);
      REG_INTEG_LIM:  ctl_ilim     = longint'(data[30:0]);
      REG_SPEED_SCL:  ctl_scale    = longint'($signed(data));
      REG_TIME_STEP:  ctl_dt       = longint'(data[30:0]);
      REG_PWM_PERIOD: ctl_period   = longint'(data[15:0]);
      REG_DEADBAND:   ctl_deadband = longint'(data[15:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Encoder beat after random source gaps, in which valid is low (none when quiet)
  task automatic push_count(input logic [15:0] cnt, input bit typed,
                            input tick_result_t want);
    tick_result_t pred;
    while (!quiet && $urandom_range(0, 99) < 17) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cnt;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = next_tick(cnt);
    pending_ticks.push_back(typed ? want : pred);
  endtask

  // Drain all results and let the sequencer come back to idle
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Sink side back-pressure
  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(0, 99) >= 17);
  end

  // Output beat check against the oldest expectation
  always @(posedge clk) begin : check_result
    tick_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.speed = m_tdata[31:0];
      got.drive = m_tdata[49:32];
      got.duty  = m_tdata[65:50];
      got.dir   = m_tdata[66];
      if (pending_ticks.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = pending_ticks.pop_front();
        if (got.speed !== want.speed)
          report_mismatch($sformatf("result %0d speed: got %0d, want %0d", results_seen,
                                    $signed(got.speed), $signed(want.speed)));
        if (got.drive !== want.drive)
          report_mismatch($sformatf("result %0d drive: got %0d, want %0d", results_seen,
                                    $signed(got.drive), $signed(want.drive)));
        if (got.duty !== want.duty)
          report_mismatch($sformatf("result %0d duty: got %0d, want %0d", results_seen,
                                    got.duty, want.duty));
        if (got.dir !== want.dir)
          report_mismatch($sformatf("result %0d direction: got %0b, want %0b",
                                    results_seen, got.dir, want.dir));
      end
      results_seen++;
    end
  end

  // Watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    dir_row_t    row;
    bit          last_cfg;
    int unsigned ph, n, r;

    // Reset state, then full-scale speed in both directions
    directed_rows.push_back(known_row(16'd1234, 32'h0, 18'h0, 16'd0, 1'b0));
    directed_rows.push_back(cfg_row(REG_SPEED_SCL, 32'h0100_0000));
    directed_rows.push_back(known_row(16'h7FFF, 32'h7FFF_0000, 18'h0, 16'd0, 1'b0));
    directed_rows.push_back(known_row(16'h8000, 32'h8000_0000, 18'h0, 16'd0, 1'b0));
    // Speed saturation at both scale extremes
    directed_rows.push_back(cfg_row(REG_SPEED_SCL, 32'h7FFF_FFFF));
    directed_rows.push_back(known_row(16'h7FFF, 32'h7FFF_FFFF, 18'h0, 16'd0, 1'b0));
    directed_rows.push_back(known_row(16'h8000, 32'h8000_0000, 18'h0, 16'd0, 1'b0));
    directed_rows.push_back(cfg_row(REG_SPEED_SCL, 32'h8000_0000));
    directed_rows.push_back(known_row(16'h8000, 32'h7FFF_FFFF, 18'h0, 16'd0, 1'b0));
    directed_rows.push_back(known_row(16'h7FFF, 32'h8000_0000, 18'h0, 16'd0, 1'b0));
    // Proportional path only, integral held at zero by a zero limit
    directed_rows.push_back(cfg_row(REG_SPEED_SCL, 32'h0));
    directed_rows.push_back(cfg_row(REG_PROP_GAIN, 32'h0001_0000));
    directed_rows.push_back(cfg_row(REG_SETPOINT, 32'h0000_8000));
    directed_rows.push_back(known_row(16'h0, 32'h0, 18'h0_8000, 16'd500, 1'b1));
    directed_rows.push_back(cfg_row(REG_SETPOINT, 32'hFFFF_8000));
    directed_rows.push_back(known_row(16'h0, 32'h0, 18'h3_8000, 16'd500, 1'b0));
    // Drive clamp at plus and minus one
    directed_rows.push_back(cfg_row(REG_SETPOINT, 32'h7FFF_FFFF));
    directed_rows.push_back(cfg_row(REG_PROP_GAIN, 32'h7FFF_FFFF));
    directed_rows.push_back(known_row(16'h0, 32'h0, 18'h1_0000, 16'd1000, 1'b1));
    directed_rows.push_back(cfg_row(REG_SETPOINT, 32'h8000_0000));
    directed_rows.push_back(known_row(16'h0, 32'h0, 18'h3_0000, 16'd1000, 1'b0));
    // Zero PWM period, then full period, then full deadband
    directed_rows.push_back(cfg_row(REG_PWM_PERIOD, 32'd0));
    directed_rows.push_back(known_row(16'h0, 32'h0, 18'h3_0000, 16'd0, 1'b0));
    directed_rows.push_back(cfg_row(REG_PWM_PERIOD, 32'hFFFF));
    directed_rows.push_back(cfg_row(REG_SETPOINT, 32'h7FFF_FFFF));
    directed_rows.push_back(known_row(16'h0, 32'h0, 18'h1_0000, 16'd65535, 1'b1));
    directed_rows.push_back(cfg_row(REG_DEADBAND, 32'hFFFF));
    directed_rows.push_back(known_row(16'h0, 32'h0, 18'h1_0000, 16'd0, 1'b1));
    // Pulse exactly at the deadband is dropped
    directed_rows.push_back(cfg_row(REG_PWM_PERIOD, 32'd1000));
    directed_rows.push_back(cfg_row(REG_DEADBAND, 32'd500));
    directed_rows.push_back(cfg_row(REG_PROP_GAIN, 32'h0001_0000));
    directed_rows.push_back(cfg_row(REG_SETPOINT, 32'h0000_8000));
    directed_rows.push_back(known_row(16'h0, 32'h0, 18'h0_8000, 16'd0, 1'b1));
    // Integrator: free running, then clamped, then extreme gain and step
    directed_rows.push_back(cfg_row(REG_SPEED_SCL, 32'h0100_0000));
    directed_rows.push_back(cfg_row(REG_INTEG_LIM, 32'h7FFF_FFFF));
    directed_rows.push_back(cfg_row(REG_INTEG_GAIN, 32'h0001_0000));
    directed_rows.push_back(cfg_row(REG_TIME_STEP, 32'h0001_0000));
    directed_rows.push_back(tick_row(16'h0));
    directed_rows.push_back(tick_row(16'hFFFF));
    directed_rows.push_back(tick_row(16'd3));
    directed_rows.push_back(cfg_row(REG_INTEG_LIM, 32'h0002_0000));
    directed_rows.push_back(tick_row(-16'sd5));
    directed_rows.push_back(tick_row(-16'sd5));
    directed_rows.push_back(tick_row(16'd7));
    directed_rows.push_back(cfg_row(REG_TIME_STEP, 32'h7FFF_FFFF));
    directed_rows.push_back(cfg_row(REG_INTEG_GAIN, 32'h7FFF_FFFF));
    directed_rows.push_back(tick_row(16'h7FFF));
    directed_rows.push_back(tick_row(16'h8000));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    last_cfg = 1'b1;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        if (!last_cfg) settle();
        cfg_write(row.idx, row.data);
      end else begin
        cfg_we <= 1'b0;
        push_count(row.cnt, row.typed, row.want);
      end
      last_cfg = row.is_cfg;
    end

    // Random phases: fresh settings each phase, one phase without idling
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      quiet = (ph == PHASES / 2);
      for (r = 0; r < 8; r++) cfg_write(r[2:0], rand_reg(r[2:0]));
      cfg_we <= 1'b0;
      for (n = 0; n < PHASE_TICKS; n++) push_count(rand_count(), 1'b0, '0);
    end

    // Drain and finish
    s_tvalid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
